/* rtl/core/stbls_pkg.sv */
// Shared types and constants for the sorted-table search unit.
package stbls_pkg;

	// Fixed field widths of the request and result items.
	localparam int POS_W    = 5;
	localparam int CNT_W    = 6;
	localparam int BCNT_W   = 3;
	localparam int LCNT_W   = 6;
	localparam int M_DATA_W = 16;

	// Request kinds carried on the input tuser.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIN_RD,
		ST_BIN_CMP,
		ST_LIN_RD,
		ST_LIN_CMP,
		ST_DONE
	} state_t;

	// Outcome of the shared compare unit for the entry just read.
	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_t;

endpackage

/* rtl/core/sorted_table_binary_linear_search_unit.sv */
// Sorted-table search unit: binary search and linear scan over a loadable table.
//
// Requests arrive on the s_ channel. tuser selects the kind: a load writes
// one table entry at position, a search looks for search_key among the first
// entry_count entries (limited to the table depth). Every request gives one
// result on the m_ channel; loads answer with all fields zero.
// The user writes the entry_count register (cfg_valid/cfg_ready/cfg_data) only
// while no request is in flight; the block does not check this. It resets to 17.
//
// A load goes from acceptance straight to the result state. A search first
// runs the binary probes, then a linear scan from entry 0 that stops at the
// first hit or after the entries in use. Both share the single table read
// port, one read per probe or scan step.
// One request is handled at a time; s_tready is high only when idle.
// The result sits in an output register, so a new request is taken while a
// finished result waits for m_tready. A stalled result holds the sequencer
// in its final state until the output register frees up.
// Reset clears the sequencer and the output valid; table contents are
// undefined until loaded.
module sorted_table_binary_linear_search_unit
	import stbls_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int VALUE_WIDTH = 16,
	localparam int S_DATA_W = ((POS_W + 2 * VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// Request channel.
	input  logic                s_tvalid,
	output logic                s_tready,
	// s_tdata: position, entry_value, search_key (zero padding on top).
	input  logic [S_DATA_W-1:0] s_tdata,
	// s_tuser: command.
	input  logic                s_tuser,
	// Result channel.
	output logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata: match_position, binary_compares, linear_compares (zero padding on top).
	output logic [M_DATA_W-1:0] m_tdata,
	// m_tuser: found.
	output logic                m_tuser,
	// entry_count register write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	state_t state_q, state_d;

	logic [CNT_W-1:0]       entry_count_q;
	logic [CNT_W-1:0]       n_eff;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]       left_q, left_d;
	logic [CNT_W-1:0]       hi_q, hi_d;
	logic [CNT_W-1:0]       mid_q, mid_d;
	logic [CNT_W:0]         mid_sum;
	logic [BCNT_W-1:0]      bcnt_q, bcnt_d;
	logic [CNT_W-1:0]       lidx_q, lidx_d;
	logic                   is_load_q;

	logic                   res_valid_q;
	logic                   res_found_q;
	logic [CNT_W-1:0]       res_pos_q;
	logic [BCNT_W-1:0]      res_bcnt_q;
	logic [LCNT_W-1:0]      res_lcnt_q;

	logic                   accept;
	logic                   out_free;
	logic                   load_res;
	logic                   rd_en;
	logic [CNT_W-1:0]       rd_idx;
	cmp_t                   cmp;

	logic [POS_W-1:0]       in_pos;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [VALUE_WIDTH-1:0] in_key;

	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_value = s_tdata[POS_W +: VALUE_WIDTH];
	assign in_key   = s_tdata[POS_W + VALUE_WIDTH +: VALUE_WIDTH];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !res_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	// Entry count in use, limited to the table depth.
	always_comb begin
		if (32'(entry_count_q) > 32'(TABLE_DEPTH)) begin
			n_eff = CNT_W'(TABLE_DEPTH);
		end else begin
			n_eff = entry_count_q;
		end
	end

	// Midpoint of the open range [left, hi).
	assign mid_sum = {1'b0, left_q} + {1'b0, hi_q} - {{CNT_W{1'b0}}, 1'b1};
	assign mid_d   = mid_sum[CNT_W:1];

	// Table storage and the shared compare unit.
	stbls_table #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (VALUE_WIDTH)
	) u_table (
		.clk     (clk),
		.wr_en   (accept && (s_tuser == CMD_LOAD) && (32'(in_pos) < 32'(TABLE_DEPTH))),
		.wr_addr (AW'(in_pos)),
		.wr_data (in_value),
		.rd_en   (rd_en),
		.rd_addr (AW'(rd_idx)),
		.key     (key_q),
		.cmp     (cmp)
	);

	// Sequencer: next state, search registers and table reads.
	always_comb begin
		state_d  = state_q;
		left_d   = left_q;
		hi_d     = hi_q;
		bcnt_d   = bcnt_q;
		lidx_d   = lidx_q;
		rd_en    = 1'b0;
		rd_idx   = mid_d;
		load_res = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					left_d = '0;
					hi_d   = n_eff;
					bcnt_d = BCNT_W'(1);
					if (s_tuser == CMD_LOAD) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_BIN_RD;
					end
				end
			end
			ST_BIN_RD: begin
				if (left_q < hi_q) begin
					rd_en   = 1'b1;
					rd_idx  = mid_d;
					state_d = ST_BIN_CMP;
				end else begin
					state_d = ST_LIN_RD;
				end
			end
			ST_BIN_CMP: begin
				if (cmp.eq) begin
					state_d = ST_LIN_RD;
				end else begin
					if (cmp.lt) begin
						left_d = mid_q + CNT_W'(1);
					end else begin
						hi_d = mid_q;
					end
					bcnt_d  = bcnt_q + BCNT_W'(1);
					state_d = ST_BIN_RD;
				end
			end
			ST_LIN_RD: begin
				rd_en   = 1'b1;
				rd_idx  = '0;
				lidx_d  = '0;
				state_d = ST_LIN_CMP;
			end
			ST_LIN_CMP: begin
				if (lidx_q >= n_eff || cmp.eq) begin
					state_d = ST_DONE;
				end else begin
					lidx_d  = lidx_q + CNT_W'(1);
					rd_en   = 1'b1;
					rd_idx  = lidx_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_W'(17);
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	// Search working registers.
	always_ff @(posedge clk) begin
		left_q <= left_d;
		hi_q   <= hi_d;
		bcnt_q <= bcnt_d;
		lidx_q <= lidx_d;
		if (state_q == ST_BIN_RD) begin
			mid_q <= mid_d;
		end
		if (accept) begin
			key_q     <= in_key;
			is_load_q <= (s_tuser == CMD_LOAD);
		end
	end

	// Output register: valid under reset, payload loaded with each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			if (is_load_q) begin
				res_found_q <= 1'b0;
				res_pos_q   <= '0;
				res_bcnt_q  <= '0;
				res_lcnt_q  <= '0;
			end else begin
				res_found_q <= (lidx_q < n_eff);
				res_pos_q   <= lidx_q;
				res_bcnt_q  <= bcnt_q;
				res_lcnt_q  <= LCNT_W'(lidx_q + CNT_W'(1));
			end
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_found_q;
	assign m_tdata  = M_DATA_W'({res_lcnt_q, res_bcnt_q, res_pos_q});

`ifndef SYNTH
	// The probe always lies inside the open search range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIN_CMP) |-> (mid_q >= left_q && mid_q < hi_q))
		else $error("binary probe outside search range");

	// The linear scan index never goes beyond the entry count in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIN_CMP) |-> (lidx_q <= n_eff))
		else $error("linear scan index past entry count");

	// A load request goes straight to the result state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_LOAD) |=> (state_q == ST_DONE))
		else $error("load request did not finish at once");

	// A found result reports one more compare than its position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (res_lcnt_q == LCNT_W'(res_pos_q + CNT_W'(1))))
		else $error("linear compare count inconsistent with position");
`endif

endmodule

/* rtl/core/stbls_table.sv */
// Entry table memory with registered read and the shared key compare unit.
module stbls_table
	import stbls_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  logic [WIDTH-1:0] key,
	output cmp_t             cmp
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Signed compare of the entry read against the key.
	always_comb begin
		cmp.eq = (rd_data_q == key);
		cmp.lt = ($signed(rd_data_q) < $signed(key));
	end

endmodule

/* verif/sorted_table_binary_linear_search_unit_tb.sv */
// Self-checking testbench for the sorted-table search unit.
module sorted_table_binary_linear_search_unit_tb;
	import stbls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = 32;
	localparam int VAL_W      = 16;
	localparam int S_DATA_W   = ((POS_W + 2 * VAL_W + 7) / 8) * 8;
	localparam int CYCLE_CAP  = 500000;
	localparam int HOLD_LEN   = 400;

	// One result as the block reports it.
	typedef struct {
		logic              found;
		logic [CNT_W-1:0]  match_pos;
		logic [BCNT_W-1:0] bin_cmp;
		logic [LCNT_W-1:0] lin_cmp;
	} search_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	// Shadow copy of the table and the entry count register.
	logic signed [VAL_W-1:0] entry_mem [DEPTH];
	logic [CNT_W-1:0]        entry_count;

	search_result_t pending_results [$];
	int error_count;
	int cycle_count;
	int hold_cycles;
	int stall_left;
	bit gaps_on;

	sorted_table_binary_linear_search_unit #(
		.TABLE_DEPTH(DEPTH),
		.VALUE_WIDTH(VAL_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run cap: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("** sorted_table_binary_linear_search_unit: FAILED **");
			$finish;
		end
	end

	// Expected answer of a search over the current shadow table: probe count of
	// the binary search and first hit of the linear scan.
	function automatic search_result_t search_outcome(logic signed [VAL_W-1:0] key);
		search_result_t res;
		int n;
		int lo;
		int hi;
		int mid;
		int probes;
		int idx;
		bit hit;
		n = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
		probes = 1;
		lo = 0;
		hi = n - 1;
		hit = 1'b0;
		while (lo <= hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (entry_mem[mid] == key) begin
				hit = 1'b1;
			end else begin
				if (entry_mem[mid] < key)
					lo = mid + 1;
				else
					hi = mid - 1;
				probes++;
			end
		end
		idx = 0;
		while (idx < n && entry_mem[idx] != key)
			idx++;
		res.found = (idx < n);
		res.match_pos = idx[CNT_W-1:0];
		res.bin_cmp = probes[BCNT_W-1:0];
		res.lin_cmp = idx[LCNT_W-1:0] + 1'b1;
		return res;
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value();
		logic [VAL_W-1:0] v;
		v = VAL_W'($urandom);
		return v;
	endfunction

	// Mostly keys that sit in the active entries or next to them, some extremes
	// and some random ones.
	function automatic logic signed [VAL_W-1:0] pick_key();
		int n;
		int r;
		logic signed [VAL_W-1:0] k;
		n = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
		r = $urandom_range(0, 99);
		if (n > 0 && r < 55)
			k = entry_mem[$urandom_range(0, n - 1)];
		else if (n > 0 && r < 70)
			k = entry_mem[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
		else if (r < 80)
			k = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		else
			k = rand_value();
		return k;
	endfunction

	// Sends one request and records its expected result when it is taken.
	// Called and left at a falling edge.
	task automatic send_request(input logic cmd, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] value, input logic signed [VAL_W-1:0] key);
		search_result_t res;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(S_DATA_W - POS_W - 2 * VAL_W){1'b0}}, key, value, pos};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_LOAD) begin
			entry_mem[pos] = value;
			res = '{1'b0, '0, '0, '0};
		end else begin
			res = search_outcome(key);
		end
		pending_results.push_back(res);
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] value);
		send_request(CMD_LOAD, pos, value, rand_value());
	endtask

	task automatic search_for(input logic signed [VAL_W-1:0] key);
		send_request(CMD_SEARCH, POS_W'($urandom), rand_value(), key);
	endtask

	// Stops offering requests and waits until every result is back.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// The register is only written with nothing in flight.
	task automatic write_entry_count(input logic [CNT_W-1:0] value);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		entry_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Loads all positions with a non-decreasing sequence from base, steps up to
	// max_step, saturating at the top of the value range.
	task automatic load_sorted(input int base, input int max_step);
		int v;
		v = base;
		for (int i = 0; i < DEPTH; i++) begin
			if (v > 32767)
				v = 32767;
			load_entry(i[POS_W-1:0], v[VAL_W-1:0]);
			v += $urandom_range(0, max_step);
		end
	endtask

	// Fills the whole table, with the value extremes at both ends, then
	// searches with the entry count left at its reset value.
	task automatic test_reset_count();
		load_sorted(-32768, 2100);
		load_entry(POS_W'(DEPTH - 1), 16'sh7fff);
		search_for(entry_mem[0]);
		search_for(entry_mem[16]);
		search_for(entry_mem[17]);
		search_for(16'sh7fff);
		repeat (4) search_for(pick_key());
	endtask

	// Small hand-built tables: extremes, duplicates, absent keys, an empty
	// table, counts above the depth and an unsorted table.
	task automatic test_corner_cases();
		write_entry_count(4);
		load_entry(0, 16'sh8000);
		load_entry(1, -16'sd100);
		load_entry(2, -16'sd100);
		load_entry(3, 16'sh7fff);
		search_for(16'sh8000);
		search_for(16'sh7fff);
		search_for(-16'sd100);
		search_for(-16'sd101);
		search_for(16'sd0);
		search_for(16'sh7ffe);
		write_entry_count(0);
		search_for(16'sh8000);
		write_entry_count(63);
		search_for(16'sh7fff);
		write_entry_count(33);
		search_for(-16'sd100);
		write_entry_count(4);
		load_entry(1, 16'sh7fff);
		search_for(16'sh7fff);
		search_for(-16'sd100);
	endtask

	// Rounds of: new count, new table content, then a burst of searches with
	// the odd load mixed in.
	task automatic test_random_rounds();
		logic [CNT_W-1:0] cnt;
		for (int round = 0; round < 12; round++) begin
			case (round)
				0: cnt = 1;
				1: cnt = 2;
				2: cnt = 32;
				3: cnt = 63;
				4: cnt = 3;
				5: cnt = 31;
				6: cnt = 33;
				7: cnt = 0;
				default: cnt = CNT_W'($urandom_range(0, 63));
			endcase
			write_entry_count(cnt);
			case (round % 4)
				0: load_sorted(-32768 + $urandom_range(0, 40000), $urandom_range(1, 2100));
				1: load_sorted(-32768, 2200);
				2: load_sorted(-32768 + $urandom_range(0, 65000), 2);
				default: begin
					// Scattered overwrites leave the table unsorted.
					repeat (6) load_entry(POS_W'($urandom), rand_value());
				end
			endcase
			repeat (30) begin
				if ($urandom_range(0, 19) == 0)
					load_entry(POS_W'($urandom), rand_value());
				else
					search_for(pick_key());
			end
		end
	endtask

	// The receiver holds off while requests keep coming, so the output
	// register fills and the block stops taking requests.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		write_entry_count(32);
		hold_cycles = HOLD_LEN;
		repeat (16) search_for(pick_key());
		gaps_on = 1'b1;
		wait_drain();
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_streaming();
		gaps_on = 1'b0;
		write_entry_count(32);
		load_sorted(-32768 + $urandom_range(0, 30000), 1500);
		repeat (40) begin
			if ($urandom_range(0, 9) == 0)
				load_entry(POS_W'($urandom), rand_value());
			else
				search_for(pick_key());
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		search_result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			$display("%0t: result with no request outstanding, actual tdata %h tuser %b",
				$time, m_tdata, m_tuser);
		end else begin
			want = pending_results.pop_front();
			check_field("found", want.found, m_tuser);
			check_field("match_position", want.match_pos, m_tdata[5:0]);
			check_field("binary_compares", want.bin_cmp, m_tdata[8:6]);
			check_field("linear_compares", want.lin_cmp, m_tdata[14:9]);
		end
	endtask

	// Result side: random stall bursts, the long hold-off, and the checks.
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (gaps_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 9);
			end
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD;
		cfg_valid = 1'b0;
		cfg_data = '0;
		entry_count = 17;
		error_count = 0;
		cycle_count = 0;
		hold_cycles = 0;
		gaps_on = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_count();
		test_corner_cases();
		test_random_rounds();
		test_backpressure();
		test_streaming();

		// Let any stray result show up before the verdict.
		wait_drain();
		repeat (60) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("** sorted_table_binary_linear_search_unit: PASSED **");
		end else begin
			if (pending_results.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_results.size());
			$display("** sorted_table_binary_linear_search_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/stbls_pkg.sv
rtl/core/stbls_table.sv
rtl/core/sorted_table_binary_linear_search_unit.sv
verif/sorted_table_binary_linear_search_unit_tb.sv
